/* src/quaternion_multiply_normalize_defines.svh */
// Assertion macros for the quaternion product checker.
`ifndef QUATERNION_MULTIPLY_NORMALIZE_DEFINES_SVH
`define QUATERNION_MULTIPLY_NORMALIZE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define QMN_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qmn check failed");

// Next-cycle implication, off during reset.
`define QMN_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qmn check failed");

// Same-cycle implication that also holds during reset.
`define QMN_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("qmn check failed");

`endif

/* src/qmn_pkg.sv */
// Shared types and widths for the normalized quaternion product.
package qmn_pkg;

  localparam int MAG_W  = 33;  // product magnitude, up to 2^32
  localparam int POS_W  = 6;   // msb position of a magnitude
  localparam int SCL_W  = 30;  // block-scaled magnitude, top bit at 29
  localparam int NORM_MSB = 29;
  localparam int SQ_W   = 60;
  localparam int SUM_W  = 62;
  localparam int ROOT_W = 31;
  localparam int M_W    = 32;  // rounded root, up to 2^31

  typedef struct packed {
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] left_z;
    logic signed [15:0] left_w;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] right_w;
  } in_t;

  typedef struct packed {
    logic signed [15:0] prod_x;
    logic signed [15:0] prod_y;
    logic signed [15:0] prod_z;
    logic signed [15:0] prod_w;
    logic               zero_norm;
  } out_t;

  typedef struct packed {
    logic [3:0][MAG_W-1:0] mag;
    logic [3:0]            neg;
    logic [MAG_W-1:0]      orv;
  } abs_t;

  typedef struct packed {
    logic [3:0][SCL_W-1:0] mag;
    logic [3:0]            neg;
    logic                  zero;
  } scl_t;

  typedef struct packed {
    logic [3:0][SCL_W-1:0] mag;
    logic [3:0]            neg;
    logic                  zero;
    logic [SUM_W-1:0]      s;
  } sq_t;

  typedef struct packed {
    logic [3:0][SCL_W-1:0] mag;
    logic [3:0]            neg;
    logic                  zero;
    logic [M_W-1:0]        m;
  } div_t;

endpackage

/* src/quaternion_multiply_normalize.sv */
// Output lanes are Q2.14 at the default FRAC_BITS of 14.
// Throughput: one item per cycle unless stalled; the whole pipeline advances together.
// Depth is set by the 31-stage square root and the FRAC_BITS+2 divider stages.
// A stall (out_valid high, out_ready low) freezes every stage; nothing is dropped.
// Reset (rst, synchronous, active high) clears all valid bits; data regs are not reset.
module quaternion_multiply_normalize #(
  parameter int FRAC_BITS = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  qmn_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output qmn_pkg::out_t out_data
);
  import qmn_pkg::*;

  // Global advance: the output register is free or is being drained.
  logic en;

  logic prod_valid, scale_valid, sqrt_valid, div_valid;
  abs_t prod_data;
  sq_t  scale_data;
  div_t sqrt_data;
  out_t div_data;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage group 1: sixteen 16x16 products, then four signed sums to magnitudes.
  qmn_prod u_prod (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid && in_ready),
    .in_data   (in_data),
    .out_valid (prod_valid),
    .out_data  (prod_data)
  );

  // Stage group 2: leading-one search, common shift, squares, sum of squares.
  qmn_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (prod_valid),
    .in_data   (prod_data),
    .out_valid (scale_valid),
    .out_data  (scale_data)
  );

  // Stage group 3: bit-per-stage square root with round to nearest.
  qmn_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (scale_valid),
    .in_data   (scale_data),
    .out_valid (sqrt_valid),
    .out_data  (sqrt_data)
  );

  // Stage group 4: four dividers in lockstep, saturation and zero handling.
  qmn_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sqrt_valid),
    .in_data   (sqrt_data),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  // Output register holds a finished item until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= div_data;
    end
  end

endmodule

/* src/qmn_prod.sv */
// Hamilton product: sixteen partial products, then signed sums and magnitudes.
module qmn_prod (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  qmn_pkg::in_t  in_data,
  output logic          out_valid,
  output qmn_pkg::abs_t out_data
);
  import qmn_pkg::*;

  logic               va;
  logic signed [31:0] pr [16];
  logic signed [31:0] pr_next [16];
  logic signed [33:0] ps [4];
  abs_t               ob_next;

  function automatic logic signed [33:0] sx(input logic signed [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

  always_comb begin
    pr_next[0]  = $signed(in_data.left_x) * $signed(in_data.right_w);
    pr_next[1]  = $signed(in_data.left_y) * $signed(in_data.right_z);
    pr_next[2]  = $signed(in_data.left_z) * $signed(in_data.right_y);
    pr_next[3]  = $signed(in_data.left_w) * $signed(in_data.right_x);
    pr_next[4]  = $signed(in_data.left_x) * $signed(in_data.right_z);
    pr_next[5]  = $signed(in_data.left_y) * $signed(in_data.right_w);
    pr_next[6]  = $signed(in_data.left_z) * $signed(in_data.right_x);
    pr_next[7]  = $signed(in_data.left_w) * $signed(in_data.right_y);
    pr_next[8]  = $signed(in_data.left_x) * $signed(in_data.right_y);
    pr_next[9]  = $signed(in_data.left_y) * $signed(in_data.right_x);
    pr_next[10] = $signed(in_data.left_z) * $signed(in_data.right_w);
    pr_next[11] = $signed(in_data.left_w) * $signed(in_data.right_z);
    pr_next[12] = $signed(in_data.left_x) * $signed(in_data.right_x);
    pr_next[13] = $signed(in_data.left_y) * $signed(in_data.right_y);
    pr_next[14] = $signed(in_data.left_z) * $signed(in_data.right_z);
    pr_next[15] = $signed(in_data.left_w) * $signed(in_data.right_w);
  end

  always_comb begin
    ps[0] =  sx(pr[0])  + sx(pr[1])  - sx(pr[2])  + sx(pr[3]);
    ps[1] = -sx(pr[4])  + sx(pr[5])  + sx(pr[6])  + sx(pr[7]);
    ps[2] =  sx(pr[8])  - sx(pr[9])  + sx(pr[10]) + sx(pr[11]);
    ps[3] = -sx(pr[12]) - sx(pr[13]) - sx(pr[14]) + sx(pr[15]);
    ob_next.orv = '0;
    for (int i = 0; i < 4; i++) begin
      ob_next.neg[i] = ps[i][33];
      ob_next.mag[i] = ps[i][33] ? MAG_W'(-ps[i]) : MAG_W'(ps[i]);
      ob_next.orv    = ob_next.orv | ob_next.mag[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= in_valid;
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr       <= pr_next;
      out_data <= ob_next;
    end
  end

endmodule

/* src/qmn_scale.sv */
// Block scaling to [2^29, 2^30), squares and their sum.
module qmn_scale (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  qmn_pkg::abs_t in_data,
  output logic          out_valid,
  output qmn_pkg::sq_t  out_data
);
  import qmn_pkg::*;

  logic                  v1, v2, v3;
  abs_t                  r1;
  logic [POS_W-1:0]      pos1, pos_next;
  scl_t                  s2, s2_next;
  scl_t                  p3;
  logic [3:0][SQ_W-1:0]  sq3, sq3_next;
  logic [2*SCL_W+NORM_MSB-1:0] wide [4];
  sq_t                   o_next;

  // msb position of the OR equals that of the largest magnitude
  always_comb begin
    pos_next = '0;
    for (int k = 0; k < MAG_W; k++) begin
      if (in_data.orv[k]) pos_next = POS_W'(k);
    end
  end

  always_comb begin
    s2_next.neg  = r1.neg;
    s2_next.zero = (r1.orv == '0);
    for (int i = 0; i < 4; i++) begin
      wide[i] = {(2*SCL_W - MAG_W)'(0), r1.mag[i], NORM_MSB'(0)} >> pos1;
      s2_next.mag[i] = wide[i][SCL_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq3_next[i] = SQ_W'(s2.mag[i]) * SQ_W'(s2.mag[i]);
    end
    o_next.mag  = p3.mag;
    o_next.neg  = p3.neg;
    o_next.zero = p3.zero;
    o_next.s    = {2'b00, sq3[0]} + {2'b00, sq3[1]} + {2'b00, sq3[2]} + {2'b00, sq3[3]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1       <= in_data;
      pos1     <= pos_next;
      s2       <= s2_next;
      p3       <= s2;
      sq3      <= sq3_next;
      out_data <= o_next;
    end
  end

endmodule

/* src/qmn_sqrt.sv */
// Pipelined square root, one root bit per stage, then round to nearest.
module qmn_sqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  qmn_pkg::sq_t  in_data,
  output logic          out_valid,
  output qmn_pkg::div_t out_data
);
  import qmn_pkg::*;

  logic [ROOT_W-1:0] vld;
  logic [SUM_W-1:0]  rem [ROOT_W];
  logic [SUM_W-1:0]  rem_next [ROOT_W];
  logic [ROOT_W-1:0] root [ROOT_W];
  logic [ROOT_W-1:0] root_next [ROOT_W];
  scl_t              pay [ROOT_W];
  scl_t              pay_next [ROOT_W];
  logic [63:0]       trial;
  logic [SUM_W-1:0]  src_rem;
  logic [ROOT_W-1:0] src_root;
  div_t              o_next;

  // remainder form: (root + 2^k)^2 - root^2 = root*2^(k+1) + 2^(2k)
  always_comb begin
    for (int j = 0; j < ROOT_W; j++) begin
      if (j == 0) begin
        src_rem     = in_data.s;
        src_root    = '0;
        pay_next[j] = '{mag: in_data.mag, neg: in_data.neg, zero: in_data.zero};
      end else begin
        src_rem     = rem[j-1];
        src_root    = root[j-1];
        pay_next[j] = pay[j-1];
      end
      trial = ({33'd0, src_root} << (ROOT_W - j)) + (64'd1 << (2 * (ROOT_W - 1 - j)));
      if ({2'b00, src_rem} >= trial) begin
        rem_next[j]  = SUM_W'({2'b00, src_rem} - trial);
        root_next[j] = src_root | (ROOT_W'(1) << (ROOT_W - 1 - j));
      end else begin
        rem_next[j]  = src_rem;
        root_next[j] = src_root;
      end
    end
  end

  always_comb begin
    o_next.mag  = pay[ROOT_W-1].mag;
    o_next.neg  = pay[ROOT_W-1].neg;
    o_next.zero = pay[ROOT_W-1].zero;
    o_next.m    = {1'b0, root[ROOT_W-1]} +
                  M_W'(rem[ROOT_W-1] > {(SUM_W-ROOT_W)'(0), root[ROOT_W-1]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[ROOT_W-2:0], in_valid};
      out_valid <= vld[ROOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem      <= rem_next;
      root     <= root_next;
      pay      <= pay_next;
      out_data <= o_next;
    end
  end

endmodule

/* src/qmn_div.sv */
// Four pipelined restoring dividers, one quotient bit per stage, with saturation.
module qmn_div #(
  parameter int FRAC_BITS = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  qmn_pkg::div_t in_data,
  output logic          out_valid,
  output qmn_pkg::out_t out_data
);
  import qmn_pkg::*;

  localparam int QW    = FRAC_BITS + 2;
  localparam int DW    = M_W + QW;
  localparam int ONE_I = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);

  logic [QW-1:0]         vld;
  logic [3:0][DW-1:0]    rem [QW];
  logic [3:0][DW-1:0]    rem_next [QW];
  logic [3:0][QW-1:0]    quo [QW];
  logic [3:0][QW-1:0]    quo_next [QW];
  logic [M_W-1:0]        dm [QW];
  logic [M_W-1:0]        dm_next [QW];
  logic [3:0]            neg [QW];
  logic [3:0]            neg_next [QW];
  logic                  zero [QW];
  logic                  zero_next [QW];
  logic [3:0][DW-1:0]    src_rem;
  logic [3:0][QW-1:0]    src_quo;
  logic [DW-1:0]         dv;
  logic [47:0]           qx, qs;
  logic [15:0]           lane [4];

  always_comb begin
    for (int j = 0; j < QW; j++) begin
      if (j == 0) begin
        for (int i = 0; i < 4; i++) begin
          src_rem[i] = (DW'(in_data.mag[i]) << FRAC_BITS) + DW'(in_data.m[M_W-1:1]);
        end
        src_quo      = '0;
        dm_next[j]   = in_data.m;
        neg_next[j]  = in_data.neg;
        zero_next[j] = in_data.zero;
      end else begin
        src_rem      = rem[j-1];
        src_quo      = quo[j-1];
        dm_next[j]   = dm[j-1];
        neg_next[j]  = neg[j-1];
        zero_next[j] = zero[j-1];
      end
      dv = DW'(dm_next[j]) << (QW - 1 - j);
      for (int i = 0; i < 4; i++) begin
        if (src_rem[i] >= dv) begin
          rem_next[j][i] = src_rem[i] - dv;
          quo_next[j][i] = src_quo[i] | (QW'(1) << (QW - 1 - j));
        end else begin
          rem_next[j][i] = src_rem[i];
          quo_next[j][i] = src_quo[i];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qx = 48'(quo[QW-1][i]);
      if (neg[QW-1][i]) begin
        qs      = (qx > 48'd32768) ? 48'd32768 : qx;
        lane[i] = 16'(48'd0 - qs);
      end else begin
        qs      = (qx > 48'd32767) ? 48'd32767 : qx;
        lane[i] = qs[15:0];
      end
    end
    if (zero[QW-1]) begin
      out_data.prod_x    = '0;
      out_data.prod_y    = '0;
      out_data.prod_z    = '0;
      out_data.prod_w    = 16'(ONE_I);
      out_data.zero_norm = 1'b1;
    end else begin
      out_data.prod_x    = lane[0];
      out_data.prod_y    = lane[1];
      out_data.prod_z    = lane[2];
      out_data.prod_w    = lane[3];
      out_data.zero_norm = 1'b0;
    end
  end

  assign out_valid = vld[QW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= rem_next;
      quo  <= quo_next;
      dm   <= dm_next;
      neg  <= neg_next;
      zero <= zero_next;
    end
  end

endmodule

/* src/qmn_check.sv */
// Port-level checker for the quaternion product block, with its bind.
`include "quaternion_multiply_normalize_defines.svh"

module qmn_check (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input qmn_pkg::out_t out_data
);
  import qmn_pkg::*;

  // vector part of the output is all zero
  logic xyz_zero;

  assign xyz_zero = (out_data.prod_x == '0) && (out_data.prod_y == '0) &&
                    (out_data.prod_z == '0);

  `QMN_ALWAYS(a_rst_clears, $past(rst) && !rst, !out_valid)
  `QMN_IMPLY(a_ready_when_empty, !out_valid, in_ready)
  `QMN_IMPLY(a_identity, out_valid && out_data.zero_norm, xyz_zero)
  `QMN_NEXT(a_valid_holds, out_valid && !out_ready, out_valid)
  `QMN_NEXT(a_data_holds, out_valid && !out_ready, $stable(out_data))

endmodule

bind quaternion_multiply_normalize qmn_check u_check (.*);
